// File: rtl/rocc_pkg.sv
// Package for the range occupancy map: transaction payload types, classified
// command type, back-end state encoding and shared constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rocc_pkg;

	// Default number of positions in the map.
	localparam int POSITIONS_DEF = 128;

	// Item kinds.
	localparam logic KIND_MARK = 1'b0;
	localparam logic KIND_LIST = 1'b1;

	// Result status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_RANGE_ERR = 1'b1;

	// Input transaction.
	typedef struct packed {
		logic       kind;
		logic [7:0] range_start;
		logic [7:0] range_end;
	} in_item_t;

	// Result transaction.
	typedef struct packed {
		logic       status;
		logic [6:0] run_count;
		logic       run_valid;
		logic [7:0] run_start;
		logic [7:0] run_end;
		logic       last;
	} out_item_t;

	// Classified command passed from the front end to the back end.
	typedef struct packed {
		logic       kind;
		logic       range_err;
		logic [7:0] range_start;
		logic [7:0] range_end;
	} cmd_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_REPORT,
		ST_LIST
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/rocc_front.sv
// Front end of the range occupancy map: accepts input transactions, checks
// the range bounds and holds classified commands in a two-entry queue.
// Depends on rocc_pkg.
`default_nettype none

module rocc_front #(
	parameter int POSITIONS = rocc_pkg::POSITIONS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  rocc_pkg::in_item_t item,
	output logic              cmd_valid,
	input  wire               cmd_ready,
	output rocc_pkg::cmd_t    cmd
);
	import rocc_pkg::*;

	localparam logic [7:0] POS_MAX = 8'(POSITIONS);

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cls;
	logic       wr_en;
	logic       rd_en;

	// Classify the incoming transaction: a zero start or a bound beyond the map
	// is a range error.
	always_comb begin
		cls.kind        = item.kind;
		cls.range_start = item.range_start;
		cls.range_end   = item.range_end;
		cls.range_err   = (item.range_start == 8'd0) || (item.range_start > POS_MAX) ||
			(item.range_end > POS_MAX);
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_valid && cmd_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/rocc_back.sv
// Back end of the range occupancy map: holds the bitmap, applies marks as a
// whole-mask update, counts runs with a bit-serial scan and emits listed runs.
// Depends on rocc_pkg.
`default_nettype none

module rocc_back #(
	parameter int POSITIONS = rocc_pkg::POSITIONS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  rocc_pkg::cmd_t     cmd,
	output logic               res_valid,
	input  wire                res_ready,
	output rocc_pkg::out_item_t res
);
	import rocc_pkg::*;

	localparam int           PW       = $clog2(POSITIONS + 1);
	localparam logic [PW-1:0] POS_LAST = PW'(POSITIONS);

	back_state_t          state_q;
	back_state_t          state_nxt;
	logic [POSITIONS-1:0] bitmap_q;
	logic [POSITIONS-1:0] scan_q;
	logic [POSITIONS-1:0] mark_mask;
	logic [POSITIONS-1:0] bitmap_nxt;
	logic [PW-1:0]        pos_q;
	logic                 in_run_q;
	logic [6:0]           runs_q;
	logic [6:0]           runs_nxt;
	logic [6:0]           emitted_q;
	logic [7:0]           begin_q;
	logic                 kind_q;
	logic                 err_q;
	logic                 bit_now;
	logic                 run_opens;
	logic                 emit;
	logic                 step;
	logic                 scan_done;

	// Mask of the positions covered by the incoming mark.
	always_comb begin
		for (int i = 0; i < POSITIONS; i++) begin
			mark_mask[i] = (8'(i + 1) >= cmd.range_start) && (8'(i + 1) <= cmd.range_end);
		end
		if ((cmd.kind == KIND_MARK) && !cmd.range_err) begin
			bitmap_nxt = bitmap_q | mark_mask;
		end else begin
			bitmap_nxt = bitmap_q;
		end
	end

	// Scan helpers: the bit under the cursor and whether a run opens there.
	assign bit_now   = scan_q[0];
	assign run_opens = bit_now && !in_run_q;
	assign runs_nxt  = runs_q + {6'd0, run_opens};
	assign scan_done = (pos_q == POS_LAST);

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_nxt = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (scan_done) begin
					if ((kind_q == KIND_LIST) && (runs_nxt != 7'd0)) begin
						state_nxt = ST_LIST;
					end else begin
						state_nxt = ST_REPORT;
					end
				end
			end
			ST_REPORT: begin
				if (res_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (step && scan_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		emit      = 1'b0;
		step      = 1'b0;
		res       = '0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			ST_COUNT: begin
				step = 1'b1;
			end
			ST_REPORT: begin
				// A mark result, or the single result of listing an empty map.
				res_valid     = 1'b1;
				res.status    = (kind_q == KIND_MARK) ? err_q : STATUS_OK;
				res.run_count = runs_q;
				res.last      = 1'b1;
			end
			ST_LIST: begin
				// A run closes on the first clear bit after it.
				emit          = in_run_q && !bit_now;
				res_valid     = emit;
				step          = !emit || res_ready;
				res.status    = STATUS_OK;
				res.run_count = runs_q;
				res.run_valid = 1'b1;
				res.run_start = begin_q;
				res.run_end   = 8'(pos_q);
				res.last      = ((emitted_q + 7'd1) == runs_q);
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// Payload registers of the current command and scan.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					scan_q <= bitmap_nxt;
					kind_q <= cmd.kind;
					err_q  <= cmd.range_err;
				end
			end
			ST_COUNT: begin
				if (scan_done && (kind_q == KIND_LIST)) begin
					scan_q <= bitmap_q;
				end else begin
					scan_q <= {1'b0, scan_q[POSITIONS-1:1]};
				end
			end
			ST_LIST: begin
				if (step) begin
					scan_q <= {1'b0, scan_q[POSITIONS-1:1]};
					if (run_opens) begin
						begin_q <= 8'(pos_q) + 8'd1;
					end
				end
			end
			default: begin
				scan_q <= scan_q;
			end
		endcase
	end

	// Control state: sequencer, bitmap, cursor and run counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bitmap_q  <= '0;
			pos_q     <= '0;
			in_run_q  <= 1'b0;
			runs_q    <= 7'd0;
			emitted_q <= 7'd0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						bitmap_q <= bitmap_nxt;
						pos_q    <= '0;
						in_run_q <= 1'b0;
						runs_q   <= 7'd0;
					end
				end
				ST_COUNT: begin
					runs_q <= runs_nxt;
					if (scan_done) begin
						pos_q     <= '0;
						in_run_q  <= 1'b0;
						emitted_q <= 7'd0;
					end else begin
						pos_q    <= pos_q + PW'(1);
						in_run_q <= bit_now;
					end
				end
				ST_LIST: begin
					if (step) begin
						pos_q    <= pos_q + PW'(1);
						in_run_q <= bit_now;
						if (emit) begin
							emitted_q <= emitted_q + 7'd1;
						end
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/rocc_out.sv
// Output register of the range occupancy map: holds one finished result and
// presents it as the head of the result queue.
// Depends on rocc_pkg.
`default_nettype none

module rocc_out (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                res_valid,
	output logic               res_ready,
	input  rocc_pkg::out_item_t res,
	output logic               empty,
	input  wire                pop,
	output rocc_pkg::out_item_t result
);
	import rocc_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// The slot takes a new result when it is free or being emptied.
	assign res_ready = !valid_q || pop;
	assign empty     = !valid_q;
	assign result    = data_q;

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

endmodule

`default_nettype wire

// File: rtl/range_occupancy_map_top.sv
// Top level of the range occupancy map: front end, back end and output
// register. Depends on rocc_pkg, rocc_front, rocc_back and rocc_out.
//
// Usage. Input transactions are written with push while full is low; each
// carries a kind (mark or list) and a one-based inclusive range. Results are
// read from the head of the result queue with pop while empty is low.
// A mark gives one result with its status and the run count after the mark.
// A list gives one result per occupied run in ascending order, or a single
// result with run_valid low when the map is empty; the final result of every
// transaction carries last.
// Timing. The front end queues up to two commands; each accepted command is
// registered in the queue before it is offered to the back end, which takes a
// new command only when it is done with the last one. The back end scans the
// bitmap one position per cycle with a bit-serial run counter and scan cursor,
// unless the receiver stalls it. A mark, or a list of an empty map, takes one
// scan of the map; a list with runs scans the map twice, and the number of
// runs lengthens it only when the receiver stalls.
// Reset clears the bitmap, the queue and the output register. When the
// receiver stalls, the back end holds its scan at the next run to report
// while the front end keeps accepting until its queue is full.
`default_nettype none

module range_occupancy_map_top #(
	parameter int POSITIONS = rocc_pkg::POSITIONS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  rocc_pkg::in_item_t  item,
	output logic               empty,
	input  wire                pop,
	output rocc_pkg::out_item_t result
);
	import rocc_pkg::*;

	logic      cmd_valid;
	logic      cmd_ready;
	cmd_t      cmd;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	// Acceptance and classification.
	rocc_front #(
		.POSITIONS(POSITIONS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	// Bitmap update and run scanning.
	rocc_back #(
		.POSITIONS(POSITIONS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Result holding register.
	rocc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

// File: test/tb_range_occupancy_map_top.sv
// Self-checking testbench for range_occupancy_map_top: mark and list
// transactions are checked against a behavioural occupancy map held here.
// Depends on rocc_pkg and range_occupancy_map_top.
`timescale 1ns / 100ps

module tb_range_occupancy_map_top;

	import rocc_pkg::*;

	localparam int POSITIONS   = POSITIONS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 2500;
	localparam int HOLD_AFTER  = 60;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  item   = '0;
	logic      full;
	logic      empty;
	out_item_t result;

	// Occupancy map as predicted, indexed by one-based position.
	logic [POSITIONS:1] occ_map;
	in_item_t           items_q[$];
	out_item_t          map_reports_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int reports_seen  = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;
	int cycle_count   = 0;

	range_occupancy_map_top #(
		.POSITIONS(POSITIONS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always #4 clk = ~clk;

	// Number of maximal occupied runs in the predicted map.
	function automatic int map_run_count();
		int  runs;
		bit  in_run;
		runs   = 0;
		in_run = 1'b0;
		for (int p = 1; p <= POSITIONS; p++) begin
			if (occ_map[p] && !in_run)
				runs++;
			in_run = occ_map[p];
		end
		return runs;
	endfunction

	// Apply one accepted transaction to the map and queue the results it causes.
	task automatic predict_map_item(input in_item_t it);
		out_item_t r;
		int        total;
		int        k;
		int        run_first;
		bit        in_run;
		r = '0;
		if (it.kind == KIND_MARK) begin
			if (it.range_start == 0 || it.range_start > POSITIONS ||
			    it.range_end > POSITIONS) begin
				r.status = STATUS_RANGE_ERR;
			end else begin
				r.status = STATUS_OK;
				for (int p = int'(it.range_start); p <= int'(it.range_end); p++)
					occ_map[p] = 1'b1;
			end
			r.run_count = 7'(map_run_count());
			r.last      = 1'b1;
			map_reports_q.push_back(r);
		end else begin
			total     = map_run_count();
			k         = 0;
			run_first = 0;
			in_run    = 1'b0;
			r.status    = STATUS_OK;
			r.run_count = 7'(total);
			if (total == 0) begin
				r.last = 1'b1;
				map_reports_q.push_back(r);
			end else begin
				// Walk one past the end so that a run touching the top closes too.
				for (int p = 1; p <= POSITIONS + 1; p++) begin
					if (p <= POSITIONS && occ_map[p] && !in_run) begin
						in_run    = 1'b1;
						run_first = p;
					end else if ((p > POSITIONS || !occ_map[p]) && in_run) begin
						in_run      = 1'b0;
						k++;
						r.run_valid = 1'b1;
						r.run_start = 8'(run_first);
						r.run_end   = 8'(p - 1);
						r.last      = (k == total);
						map_reports_q.push_back(r);
					end
				end
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
	                               input logic [7:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic void add_item(input logic kind, input int s, input int e);
		in_item_t it;
		it.kind        = kind;
		it.range_start = 8'(s);
		it.range_end   = 8'(e);
		items_q.push_back(it);
	endfunction

	// One random transaction: mostly well-formed marks of bounded length,
	// some lists and some arbitrary field values.
	function automatic void add_random_item(input int max_len);
		int roll;
		int s;
		roll = $urandom_range(0, 99);
		if (roll < 62) begin
			s = $urandom_range(1, POSITIONS);
			add_item(KIND_MARK, s, s + $urandom_range(0, max_len));
		end else if (roll < 80) begin
			add_item(KIND_LIST, $urandom_range(0, 255), $urandom_range(0, 255));
		end else if (roll < 88) begin
			s = $urandom_range(2, POSITIONS);
			add_item(KIND_MARK, s, $urandom_range(0, s - 1));
		end else begin
			add_item(KIND_MARK, $urandom_range(0, 255), $urandom_range(0, 255));
		end
	endfunction

	// Sender: holds an offered transaction until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_map_item(item);
				void'(items_q.pop_front());
			end
			if (!push || !full) begin
				if (items_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					push <= 1'b1;
					item <= items_q[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off mid-run, counted here, so that the block
	// fills and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && reports_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: checks every result taken against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				reports_seen <= reports_seen + 1;
				if (map_reports_q.size() == 0) begin
					report_mismatch("unexpected result, run_count", 8'(result.run_count),
					                8'd0);
				end else begin
					if (result.status !== map_reports_q[0].status)
						report_mismatch("status", 8'(result.status),
						                8'(map_reports_q[0].status));
					if (result.run_count !== map_reports_q[0].run_count)
						report_mismatch("run_count", 8'(result.run_count),
						                8'(map_reports_q[0].run_count));
					if (result.run_valid !== map_reports_q[0].run_valid)
						report_mismatch("run_valid", 8'(result.run_valid),
						                8'(map_reports_q[0].run_valid));
					if (result.run_start !== map_reports_q[0].run_start)
						report_mismatch("run_start", result.run_start,
						                map_reports_q[0].run_start);
					if (result.run_end !== map_reports_q[0].run_end)
						report_mismatch("run_end", result.run_end, map_reports_q[0].run_end);
					if (result.last !== map_reports_q[0].last)
						report_mismatch("last", 8'(result.last), 8'(map_reports_q[0].last));
					void'(map_reports_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (items_q.size() != 0 || map_reports_q.size() != 0 || push)
			@(posedge clk);
	endtask

	// Stimulus sequence and end of run.
	initial begin
		int odd_pos[64];
		int j;
		int tmp;
		occ_map = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 15;
		recv_idle_pct = 59;

		// Directed: empty list, edges of the map, range errors, empty ranges.
		add_item(KIND_LIST, 0, 0);
		add_item(KIND_MARK, 1, 1);
		add_item(KIND_MARK, POSITIONS, POSITIONS);
		add_item(KIND_LIST, 0, 0);
		add_item(KIND_MARK, 0, 0);
		add_item(KIND_MARK, 0, 255);
		add_item(KIND_MARK, POSITIONS + 1, POSITIONS + 1);
		add_item(KIND_MARK, 1, POSITIONS + 1);
		add_item(KIND_MARK, 255, 255);
		add_item(KIND_MARK, 5, 255);
		add_item(KIND_MARK, 9, 3);
		add_item(KIND_MARK, POSITIONS, POSITIONS - 1);
		add_item(KIND_LIST, 255, 255);
		add_item(KIND_MARK, 1, 1);
		add_item(KIND_MARK, 3, 3);
		add_item(KIND_LIST, 0, 0);

		// Comb build: every odd position marked in random order, interleaved with random
		// lists and arbitrary marks, to drive the map towards the largest possible number of runs.
		for (int i = 0; i < 64; i++)
			odd_pos[i] = 2 * i + 1;
		for (int i = 63; i > 0; i--) begin
			j          = $urandom_range(0, i);
			tmp        = odd_pos[i];
			odd_pos[i] = odd_pos[j];
			odd_pos[j] = tmp;
		end
		for (int i = 0; i < 64; i++) begin
			add_item(KIND_MARK, odd_pos[i], odd_pos[i]);
			if (i % 8 == 7)
				add_item(KIND_LIST, $urandom_range(0, 255), $urandom_range(0, 255));
			if (i % 13 == 12)
				add_item(KIND_MARK, $urandom_range(0, 255), $urandom_range(0, 255));
		end
		add_item(KIND_LIST, 0, 0);
		wait_drained();

		// Short ranges that merge the comb runs step by step.
		send_idle_pct = 59;
		recv_idle_pct = 15;
		for (int i = 0; i < 30; i++)
			add_random_item(3);
		wait_drained();

		// Longer ranges with no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 20; i++)
			add_random_item(40);
		add_item(KIND_MARK, 1, POSITIONS);
		add_item(KIND_LIST, 0, 0);
		wait_drained();

		repeat (4 * POSITIONS + 16) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
